[design/rcs_pkg.sv]
package rcs_pkg;

	localparam int unsigned ADDR_W = 16;
	localparam int unsigned COST_W = 16;
	localparam int unsigned ENERGY_W = 32;
	localparam int unsigned DIST_W = 32;
	localparam int unsigned SCALE_W = 16;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned PROD_W = 48;
	localparam int unsigned DIV_STEPS = 48;
	localparam int unsigned DIV_CNT_W = 6;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_SELECT = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_ZERO_DIST = 2'd3;

	localparam logic [1:0] REG_ENERGY_MAX = 2'd0;
	localparam logic [1:0] REG_COST_SCALE = 2'd1;
	localparam logic [1:0] REG_TYPICAL_DELAY = 2'd2;

	localparam logic [ENERGY_W-1:0] ENERGY_MAX_RST = 32'hFFFF_FFFF;
	localparam logic [SCALE_W-1:0] COST_SCALE_RST = 16'd1000;
	localparam logic [DELAY_W-1:0] TYPICAL_DELAY_RST = 16'd10;

	localparam logic [ADDR_W-1:0] NO_RELAY = 16'hFFFF;
	localparam logic [COST_W-1:0] COST_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0] operation;
		logic [ADDR_W-1:0] responder_addr;
		logic [ENERGY_W-1:0] energy;
		logic [DIST_W-1:0] distance;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [ADDR_W-1:0] best_addr;
		logic [COST_W-1:0] best_cost;
		logic [COST_W-1:0] stored_cost;
	} rsp_t;

	typedef struct packed {
		logic [1:0] index;
		logic [31:0] value;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [COST_W-1:0] cost;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[design/rcs_chan_if.sv]
interface rcs_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[design/rcs_ram.sv]
module rcs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/rcs_div.sv]
module rcs_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [rcs_pkg::PROD_W-1:0] num,
	input  logic [rcs_pkg::PROD_W-1:0] den,
	output logic done,
	output logic [rcs_pkg::PROD_W-1:0] quotient
);
	localparam int unsigned W = rcs_pkg::PROD_W;

	logic busy_q;
	logic done_q;
	logic [rcs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] den_q;
	logic [W:0] shifted;
	logic [W:0] trial;

	// restoring step: shift in the next numerator bit, keep the difference if it fits
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + rcs_pkg::DIV_CNT_W'(1);
				if (cnt_q == rcs_pkg::DIV_CNT_W'(rcs_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
			end else begin
				rem_q <= shifted[W-1:0];
			end
			quo_q <= {quo_q[W-2:0], ~trial[W]};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

[design/relay_candidate_selector.sv]
// Sequence: clear, unused operations, an add with zero distance or delay, and a select on an
// empty table go from idle straight to push. Other adds pass the numerator and denominator
// multiply states, divider start and the 48-step divider wait before push. A select reads and
// checks each stored entry for the best cost, then rescans to the first entry with that address.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (arst_n, asynchronous): table emptied by count, registers to defaults, no RAM sweep.
module relay_candidate_selector #(
	parameter int unsigned TABLE_DEPTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	rcs_chan_if.sink req,
	rcs_chan_if.source rsp,
	rcs_chan_if.sink cfg
);
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b00_0000_0001,
		ST_MUL_NUM   = 10'b00_0000_0010,
		ST_MUL_DEN   = 10'b00_0000_0100,
		ST_DIV_START = 10'b00_0000_1000,
		ST_DIV_WAIT  = 10'b00_0001_0000,
		ST_SCAN1_RD  = 10'b00_0010_0000,
		ST_SCAN1_CHK = 10'b00_0100_0000,
		ST_SCAN2_RD  = 10'b00_1000_0000,
		ST_SCAN2_CHK = 10'b01_0000_0000,
		ST_PUSH      = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [rcs_pkg::ENERGY_W-1:0] energy_max_q;
	logic [rcs_pkg::SCALE_W-1:0] cost_scale_q;
	logic [rcs_pkg::DELAY_W-1:0] typical_delay_q;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;

	logic [rcs_pkg::ADDR_W-1:0] addr_q;
	logic [rcs_pkg::ENERGY_W-1:0] energy_q;
	logic [rcs_pkg::DIST_W-1:0] dist_q;
	logic [rcs_pkg::PROD_W-1:0] num_q;
	logic [rcs_pkg::PROD_W-1:0] den_q;
	logic [rcs_pkg::COST_W-1:0] best_cost_q;
	logic [rcs_pkg::ADDR_W-1:0] best_addr_q;

	rcs_pkg::rsp_t res_q;
	rcs_pkg::rsp_t out_q;
	logic out_valid_q;

	logic [rcs_pkg::ENERGY_W-1:0] mul_a;
	logic [rcs_pkg::SCALE_W-1:0] mul_b;
	logic [rcs_pkg::PROD_W-1:0] mul_prod;

	logic div_start;
	logic div_done;
	logic [rcs_pkg::PROD_W-1:0] div_quo;
	logic [rcs_pkg::COST_W-1:0] sat_cost;

	logic ram_we;
	logic [rcs_pkg::ENTRY_W-1:0] ram_wdata;
	logic [rcs_pkg::ENTRY_W-1:0] ram_rdata;
	rcs_pkg::entry_t ent;
	rcs_pkg::entry_t wr_ent;

	logic table_full;
	logic last_entry;
	logic can_load;
	logic accept;

	// configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_max_q <= rcs_pkg::ENERGY_MAX_RST;
			cost_scale_q <= rcs_pkg::COST_SCALE_RST;
			typical_delay_q <= rcs_pkg::TYPICAL_DELAY_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				rcs_pkg::REG_ENERGY_MAX: energy_max_q <= cfg.data.value;
				rcs_pkg::REG_COST_SCALE: cost_scale_q <= cfg.data.value[rcs_pkg::SCALE_W-1:0];
				rcs_pkg::REG_TYPICAL_DELAY: begin
					typical_delay_q <= cfg.data.value[rcs_pkg::DELAY_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// shared multiplier: numerator first, then denominator
	always_comb begin
		if (state_q == ST_MUL_NUM) begin
			mul_a = energy_q;
			mul_b = cost_scale_q;
		end else begin
			mul_a = dist_q;
			mul_b = typical_delay_q;
		end
	end

	assign mul_prod = rcs_pkg::PROD_W'(mul_a) * rcs_pkg::PROD_W'(mul_b);

	assign div_start = (state_q == ST_DIV_START);

	rcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num_q),
		.den      (den_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign sat_cost = (div_quo[rcs_pkg::PROD_W-1:rcs_pkg::COST_W] != '0) ?
		rcs_pkg::COST_MAX : div_quo[rcs_pkg::COST_W-1:0];

	assign table_full = (count_q >= CNT_W'(TABLE_DEPTH));
	assign ram_we = (state_q == ST_DIV_WAIT) && div_done && !table_full;
	assign wr_ent.addr = addr_q;
	assign wr_ent.cost = sat_cost;
	assign ram_wdata = wr_ent;
	assign ent = ram_rdata;

	rcs_ram #(
		.WIDTH (rcs_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign last_entry = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));
	assign can_load = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_PUSH && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						unique case (req.data.operation)
							rcs_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= ST_PUSH;
							end
							rcs_pkg::OP_ADD: begin
								if (req.data.distance == '0 || typical_delay_q == '0) begin
									state_q <= ST_PUSH;
								end else begin
									state_q <= ST_MUL_NUM;
								end
							end
							rcs_pkg::OP_SELECT: begin
								if (count_q == '0) begin
									state_q <= ST_PUSH;
								end else begin
									state_q <= ST_SCAN1_RD;
								end
							end
							default: state_q <= ST_PUSH;
						endcase
					end
				end
				ST_MUL_NUM: state_q <= ST_MUL_DEN;
				ST_MUL_DEN: state_q <= ST_DIV_START;
				ST_DIV_START: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (!table_full) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_PUSH;
					end
				end
				ST_SCAN1_RD: state_q <= ST_SCAN1_CHK;
				ST_SCAN1_CHK: begin
					if (last_entry) begin
						idx_q <= '0;
						state_q <= ST_SCAN2_RD;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						state_q <= ST_SCAN1_RD;
					end
				end
				ST_SCAN2_RD: state_q <= ST_SCAN2_CHK;
				ST_SCAN2_CHK: begin
					if (ent.addr == best_addr_q || last_entry) begin
						state_q <= ST_PUSH;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						state_q <= ST_SCAN2_RD;
					end
				end
				ST_PUSH: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				addr_q <= req.data.responder_addr;
				energy_q <= (req.data.energy > energy_max_q) ? energy_max_q : req.data.energy;
				dist_q <= req.data.distance;
				best_cost_q <= '0;
				best_addr_q <= rcs_pkg::NO_RELAY;
				res_q.best_cost <= '0;
				res_q.stored_cost <= '0;
				if (req.data.operation == rcs_pkg::OP_ADD) begin
					res_q.status <= rcs_pkg::STAT_ZERO_DIST;
					res_q.best_addr <= '0;
				end else if (req.data.operation == rcs_pkg::OP_SELECT) begin
					res_q.status <= rcs_pkg::STAT_EMPTY;
					res_q.best_addr <= rcs_pkg::NO_RELAY;
				end else begin
					res_q.status <= rcs_pkg::STAT_OK;
					res_q.best_addr <= '0;
				end
			end
			ST_MUL_NUM: num_q <= mul_prod;
			ST_MUL_DEN: den_q <= mul_prod;
			ST_DIV_WAIT: begin
				res_q.status <= table_full ? rcs_pkg::STAT_FULL : rcs_pkg::STAT_OK;
				res_q.stored_cost <= sat_cost;
			end
			ST_SCAN1_CHK: begin
				// later entries win ties
				if (ent.cost >= best_cost_q) begin
					best_cost_q <= ent.cost;
					best_addr_q <= ent.addr;
				end
			end
			ST_SCAN2_CHK: begin
				res_q.status <= rcs_pkg::STAT_OK;
				res_q.best_addr <= best_addr_q;
				res_q.best_cost <= ent.cost;
				res_q.stored_cost <= '0;
			end
			ST_PUSH: begin
				if (can_load) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after taking a beat");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

	a_write_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (count_q < CNT_W'(TABLE_DEPTH)))
		else $error("table written while full");
`endif

endmodule

[verif/relay_candidate_selector_tb.sv]
`timescale 1ns / 100ps

module relay_candidate_selector_tb;

	localparam int unsigned DEPTH = 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// the whole run stops with an error once the cycle counter reaches this limit
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned PHASES = 7;

	logic clk;
	logic arst_n;

	rcs_chan_if #(.T(rcs_pkg::req_t)) req_if ();
	rcs_chan_if #(.T(rcs_pkg::rsp_t)) rsp_if ();
	rcs_chan_if #(.T(rcs_pkg::cfg_t)) cfg_if ();

	relay_candidate_selector #(.TABLE_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// shadow copy of the registers and the candidate table
	logic [31:0] energy_ceiling;
	logic [15:0] scale_factor;
	logic [15:0] delay_factor;
	logic [15:0] table_addr [DEPTH];
	logic [15:0] table_cost [DEPTH];
	int unsigned table_used;

	rcs_pkg::req_t pending_reqs[$];
	rcs_pkg::rsp_t predicted_results[$];
	bit calm_flow;
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned recv_wait;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned n_clear = 0;
	int unsigned n_add = 0;
	int unsigned n_select = 0;
	int unsigned n_full = 0;
	int unsigned n_zero_dist = 0;
	int unsigned n_empty = 0;
	int unsigned n_unused = 0;
	int unsigned n_saturated = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				predicted_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic rcs_pkg::rsp_t link_cost_outcome(rcs_pkg::req_t r);
		rcs_pkg::rsp_t o;
		logic [31:0] e;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] q;
		logic [15:0] cost;
		logic [15:0] top_val;
		logic [15:0] top_addr;
		bit found;
		o = '0;
		case (r.operation)
		rcs_pkg::OP_CLEAR: begin
			table_used = 0;
			n_clear++;
		end
		rcs_pkg::OP_ADD: begin
			n_add++;
			e = (r.energy > energy_ceiling) ? energy_ceiling : r.energy;
			den = 64'(delay_factor) * 64'(r.distance);
			if (den == 0) begin
				o.status = rcs_pkg::STAT_ZERO_DIST;
				n_zero_dist++;
			end else begin
				num = 64'(e) * 64'(scale_factor);
				q = num / den;
				if (q > 64'(rcs_pkg::COST_MAX)) begin
					cost = rcs_pkg::COST_MAX;
					n_saturated++;
				end else begin
					cost = q[15:0];
				end
				o.stored_cost = cost;
				if (table_used < DEPTH) begin
					table_addr[table_used] = r.responder_addr;
					table_cost[table_used] = cost;
					table_used++;
				end else begin
					o.status = rcs_pkg::STAT_FULL;
					n_full++;
				end
			end
		end
		rcs_pkg::OP_SELECT: begin
			n_select++;
			if (table_used == 0) begin
				o.status = rcs_pkg::STAT_EMPTY;
				o.best_addr = rcs_pkg::NO_RELAY;
				n_empty++;
			end else begin
				top_val = '0;
				top_addr = rcs_pkg::NO_RELAY;
				// later entries win ties
				for (int i = 0; i < table_used; i++)
					if (table_cost[i] >= top_val) begin
						top_val = table_cost[i];
						top_addr = table_addr[i];
					end
				// report the cost of the first entry holding that address
				found = 1'b0;
				for (int i = 0; i < table_used && !found; i++)
					if (table_addr[i] == top_addr) begin
						o.best_cost = table_cost[i];
						found = 1'b1;
					end
				o.best_addr = top_addr;
			end
		end
		default: n_unused++;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	task automatic compare_relay_result(rcs_pkg::rsp_t got);
		rcs_pkg::rsp_t want;
		if (predicted_results.size() == 0) begin
			report_mismatch("result with no prediction waiting", 32'(got.best_addr), '0);
			return;
		end
		want = predicted_results.pop_front();
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.best_addr !== want.best_addr)
			report_mismatch("best_addr", 32'(got.best_addr), 32'(want.best_addr));
		if (got.best_cost !== want.best_cost)
			report_mismatch("best_cost", 32'(got.best_cost), 32'(want.best_cost));
		if (got.stored_cost !== want.stored_cost)
			report_mismatch("stored_cost", 32'(got.stored_cost), 32'(want.stored_cost));
	endtask

	// request driver: predict on each accepted beat, then wait out the drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data <= '0;
			send_gap <= 0;
			table_used = 0;
		end else begin
			if (req_if.valid && req_if.ready)
				predicted_results.push_back(link_cost_outcome(req_if.data));
			if (!req_if.valid || req_if.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					req_if.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req_if.valid <= 1'b1;
					req_if.data <= pending_reqs.pop_front();
					send_gap <= calm_flow ? 0 : $urandom_range(0, 7);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: after each beat, hold ready low for a drawn number of valid cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				compare_relay_result(rsp_if.data);
				recv_wait = calm_flow ? 0 : $urandom_range(0, 7);
				recv_stall <= recv_wait;
				rsp_if.ready <= (recv_wait == 0);
			end else if (recv_stall != 0) begin
				if (rsp_if.valid)
					recv_stall <= recv_stall - 1;
				rsp_if.ready <= rsp_if.valid && recv_stall == 1;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_ceiling = rcs_pkg::ENERGY_MAX_RST;
			scale_factor = rcs_pkg::COST_SCALE_RST;
			delay_factor = rcs_pkg::TYPICAL_DELAY_RST;
		end else if (cfg_if.valid && cfg_if.ready) begin
			case (cfg_if.data.index)
			rcs_pkg::REG_ENERGY_MAX: energy_ceiling = cfg_if.data.value;
			rcs_pkg::REG_COST_SCALE: scale_factor = cfg_if.data.value[15:0];
			rcs_pkg::REG_TYPICAL_DELAY: delay_factor = cfg_if.data.value[15:0];
			default: ;
			endcase
		end
	end

	task automatic push_req(logic [1:0] op, logic [15:0] addr, logic [31:0] energy,
		logic [31:0] distance);
		rcs_pkg::req_t r;
		r.operation = op;
		r.responder_addr = addr;
		r.energy = energy;
		r.distance = distance;
		pending_reqs.push_back(r);
	endtask

	// leaves valid high; the caller lowers it after the last beat
	task automatic write_register(logic [1:0] idx, logic [31:0] val);
		rcs_pkg::cfg_t w;
		w.index = idx;
		w.value = val;
		cfg_if.valid <= 1'b1;
		cfg_if.data <= w;
		do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
	endtask

	task automatic apply_settings(logic [31:0] ceiling, logic [15:0] scale, logic [15:0] delay);
		write_register(rcs_pkg::REG_ENERGY_MAX, ceiling);
		write_register(rcs_pkg::REG_COST_SCALE, 32'(scale));
		write_register(rcs_pkg::REG_TYPICAL_DELAY, 32'(delay));
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || req_if.valid || predicted_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic rcs_pkg::req_t random_add();
		rcs_pkg::req_t r;
		r.operation = rcs_pkg::OP_ADD;
		// a small address pool makes repeated addresses common
		r.responder_addr = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 5))
			: 16'($urandom);
		case ($urandom_range(0, 7))
		0: r.energy = $urandom;
		1: r.energy = '1;
		default: r.energy = $urandom >> $urandom_range(0, 31);
		endcase
		case ($urandom_range(0, 15))
		0: r.distance = '0;
		1: r.distance = $urandom;
		2: r.distance = '1;
		default: r.distance = $urandom >> $urandom_range(4, 31);
		endcase
		return r;
	endfunction

	task automatic queue_random_items(int unsigned count);
		int unsigned made;
		int unsigned adds;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 7) == 0) begin
				// noise: any operation with any payload
				push_req(2'($urandom_range(0, 3)), 16'($urandom), $urandom, $urandom);
				if (pending_reqs[$].operation != OP_UNUSED)
					made++;
			end else begin
				if ($urandom_range(0, 3) != 0) begin
					push_req(rcs_pkg::OP_CLEAR, '0, '0, '0);
					made++;
				end
				adds = $urandom_range(0, 11);
				repeat (adds) begin
					pending_reqs.push_back(random_add());
					made++;
					if ($urandom_range(0, 9) == 0) begin
						push_req(rcs_pkg::OP_SELECT, '0, '0, '0);
						made++;
					end
				end
				push_req(rcs_pkg::OP_SELECT, '0, '0, '0);
				made++;
			end
		end
	endtask

	task automatic queue_directed_items();
		push_req(rcs_pkg::OP_SELECT, '0, '0, '0);
		push_req(rcs_pkg::OP_ADD, 16'h0000, 32'd0, 32'd1);
		push_req(rcs_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'd1);
		push_req(rcs_pkg::OP_ADD, 16'h1234, 32'd5, 32'd0);
		push_req(rcs_pkg::OP_ADD, 16'h00AA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(rcs_pkg::OP_ADD, 16'h5555, 32'd655350, 32'd1);
		// saturated tie on an address seen earlier with a lower cost
		push_req(rcs_pkg::OP_ADD, 16'h00AA, 32'd1000000, 32'd1);
		push_req(rcs_pkg::OP_SELECT, '0, '0, '0);
		push_req(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(rcs_pkg::OP_ADD, 16'h8000, 32'd70, 32'd7);
		push_req(rcs_pkg::OP_ADD, 16'h7FFF, 32'd123456, 32'd1000);
		push_req(rcs_pkg::OP_ADD, 16'h0001, 32'd1, 32'd1);
		// table is full now
		push_req(rcs_pkg::OP_ADD, 16'h4321, 32'd100, 32'd1);
		push_req(rcs_pkg::OP_ADD, 16'h4321, 32'd100, 32'd0);
		push_req(rcs_pkg::OP_SELECT, '0, '0, '0);
		push_req(rcs_pkg::OP_CLEAR, '0, '0, '0);
		push_req(rcs_pkg::OP_SELECT, '0, '0, '0);
		push_req(rcs_pkg::OP_ADD, 16'h2222, 32'd0, 32'hFFFF_FFFF);
		push_req(rcs_pkg::OP_SELECT, '0, '0, '0);
		push_req(rcs_pkg::OP_CLEAR, '0, '0, '0);
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		calm_flow = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_directed_items();
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: ;
			1: apply_settings(32'd0, 16'hFFFF, 16'd1);
			2: apply_settings(32'hFFFF_FFFF, 16'hFFFF, 16'd1);
			3: apply_settings($urandom, 16'd1, 16'hFFFF);
			default: apply_settings($urandom, 16'($urandom_range(1, 65535)),
				16'($urandom_range(1, 65535)));
			endcase
			calm_flow = 1'b0;
			queue_random_items(80);
			// hold the sender until every result of the first half is back
			wait_drained();
			calm_flow = ($urandom_range(0, 1) == 1);
			queue_random_items(70);
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d adds (%0d saturated, %0d on a full table, %0d zero distance)",
			n_add, n_saturated, n_full, n_zero_dist);
		$display("plus %0d selects (%0d empty), %0d clears, %0d unused ops over %0d settings",
			n_select, n_empty, n_clear, n_unused, PHASES);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
